@@ design/cds_pkg.sv @@
// Shared constants, types and the standard-order card function for the deck shuffler.
package cds_pkg;

    localparam int WORD_W   = 31;
    localparam int POS_W    = 6;
    localparam int RANK_W   = 4;
    localparam int SUIT_W   = 2;
    localparam int CARD_W   = RANK_W + SUIT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int DIV_CNT_W  = $clog2(WORD_W + 1);

    localparam logic [RANK_W-1:0] TOP_RANK = 4'd13;
    localparam logic [RANK_W-1:0] MIN_RANK = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_RANK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUFFLE_LENGTH = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD_I,
        ST_RD_J,
        ST_WR_J,
        ST_WR_I
    } state_t;

    typedef logic [CARD_W-1:0] card_t;

    function automatic card_t build_card(logic [6:0] k, logic [RANK_W-1:0] lo);
        logic [RANK_W-1:0] n;
        logic [6:0]        n1;
        logic [6:0]        n2;
        logic [6:0]        n3;
        logic [6:0]        n4;
        logic [6:0]        off;
        logic [SUIT_W-1:0] suit;
        card_t             card;
        n    = TOP_RANK + 4'd1 - lo;
        n1   = {3'b000, n};
        n2   = n1 << 1;
        n3   = n2 + n1;
        n4   = n1 << 2;
        suit = 2'd0;
        off  = k;
        if (k < n1)
        begin
            suit = 2'd0;
            off  = k;
        end
        else if (k < n2)
        begin
            suit = 2'd1;
            off  = k - n1;
        end
        else if (k < n3)
        begin
            suit = 2'd2;
            off  = k - n2;
        end
        else
        begin
            suit = 2'd3;
            off  = k - n3;
        end
        if (k < n4)
            card = {suit, lo + off[RANK_W-1:0]};
        else
            card = '0;
        return card;
    endfunction

endpackage

@@ design/card_deck_shuffle.sv @@
// Top level: Fisher-Yates deck shuffler, one final card per random word.
//
// Each transfer on start/busy carries one random word and yields exactly one card. The card
// is on the result ports for a single cycle with done high; the receiver cannot stall.
// An item passes through these steps from accept to the next possible accept:
// - modulo: 31 bit-serial steps reduce the 31-bit word by the remaining count,
//   and then the divider flags the remainder.
// - the deck memory: two reads and two writes.
// - the idle state, in which busy is low again.
// The card strobe falls in that idle state, so it is taken at the same edge as the next
// item can be. cfg_ready is low while busy is high and while start is high.
// The deck is rebuilt in standard order at once after reset, after any register write and
// after the last card, since each entry carries a valid flag and an unwritten entry reads
// as its standard-order card.
module card_deck_shuffle #(
    parameter int DECK_SIZE = 52
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cds_pkg::WORD_W-1:0]       random_word,
    output logic                             done,
    output logic [cds_pkg::POS_W-1:0]        position,
    output logic [cds_pkg::RANK_W-1:0]       card_rank,
    output logic [cds_pkg::SUIT_W-1:0]       card_suit,
    output logic                             last_card,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cds_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;

    cds_pkg::state_t state_reg;
    cds_pkg::state_t state_next;

    logic [cds_pkg::RANK_W-1:0] lowest_rank_reg;
    logic [cds_pkg::POS_W-1:0]  shuffle_length_reg;
    logic [cds_pkg::POS_W-1:0]  step_reg;
    logic [cds_pkg::POS_W-1:0]  i_reg;
    logic [cds_pkg::POS_W-1:0]  rem_reg;
    logic [ADDR_W-1:0]          j_reg;
    logic                       last_reg;
    cds_pkg::card_t             card_i_reg;
    cds_pkg::card_t             card_j_reg;

    cds_pkg::card_t             mem [DECK_SIZE];
    logic [DECK_SIZE-1:0]       valid_reg;
    cds_pkg::card_t             rd_data_reg;
    logic                       rd_valid_reg;
    logic [ADDR_W-1:0]          rd_addr_reg;

    logic                       done_reg;
    logic [cds_pkg::POS_W-1:0]  position_reg;
    logic [cds_pkg::RANK_W-1:0] card_rank_reg;
    logic [cds_pkg::SUIT_W-1:0] card_suit_reg;
    logic                       last_card_reg;

    logic [cds_pkg::RANK_W-1:0] eff_lo;
    logic [cds_pkg::RANK_W-1:0] suit_len;
    logic [6:0]                 built_cnt;
    logic [6:0]                 len_wide;
    logic [cds_pkg::POS_W-1:0]  len;
    logic [cds_pkg::POS_W-1:0]  i_start;
    logic [6:0]                 j_sum;
    logic [ADDR_W-1:0]          j_calc;
    logic [ADDR_W-1:0]          rd_addr;
    cds_pkg::card_t             rd_card;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    cds_pkg::card_t             wr_data;
    logic                       accept;
    logic                       cfg_write;
    logic                       rebuild;
    logic                       div_done;
    logic [cds_pkg::POS_W-1:0]  div_rem;

    assign cfg_ready = !busy && !start;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index == cds_pkg::CFG_LOWEST_RANK ||
                        cfg_index == cds_pkg::CFG_SHUFFLE_LENGTH);
    assign busy      = (state_reg != cds_pkg::ST_IDLE);
    assign accept    = start && !busy;

    always_comb
    begin
        if (lowest_rank_reg < cds_pkg::MIN_RANK)
            eff_lo = cds_pkg::MIN_RANK;
        else if (lowest_rank_reg > cds_pkg::TOP_RANK)
            eff_lo = cds_pkg::TOP_RANK;
        else
            eff_lo = lowest_rank_reg;
        suit_len  = cds_pkg::TOP_RANK + 4'd1 - eff_lo;
        built_cnt = {3'b000, suit_len} << 2;
        if (built_cnt > 7'(DECK_SIZE))
            built_cnt = 7'(DECK_SIZE);
        len_wide = {1'b0, shuffle_length_reg};
        if (len_wide > built_cnt)
            len_wide = built_cnt;
        if (len_wide < 7'd1)
            len_wide = 7'd1;
        len = len_wide[cds_pkg::POS_W-1:0];
        i_start = (step_reg >= len) ? '0 : step_reg;
        j_sum = {1'b0, i_reg} + {1'b0, div_rem};
        if (j_sum >= 7'(DECK_SIZE))
            j_calc = i_reg[ADDR_W-1:0];
        else
            j_calc = j_sum[ADDR_W-1:0];
    end

    cds_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (random_word),
        .divisor   (len - i_start),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cds_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        rd_addr    = i_reg[ADDR_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = j_reg;
        wr_data    = card_i_reg;
        case (state_reg)
            cds_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = cds_pkg::ST_DIV;
            end
            cds_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = cds_pkg::ST_RD_I;
            end
            cds_pkg::ST_RD_I:
            begin
                state_next = cds_pkg::ST_RD_J;
            end
            cds_pkg::ST_RD_J:
            begin
                rd_addr    = j_reg;
                state_next = cds_pkg::ST_WR_J;
            end
            cds_pkg::ST_WR_J:
            begin
                wr_en      = 1'b1;
                state_next = cds_pkg::ST_WR_I;
            end
            cds_pkg::ST_WR_I:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[ADDR_W-1:0];
                wr_data    = card_j_reg;
                state_next = cds_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cds_pkg::ST_IDLE;
            end
        endcase
    end

    assign rd_card = rd_valid_reg ? rd_data_reg
                                  : cds_pkg::build_card(7'(rd_addr_reg), eff_lo);
    assign rebuild = cfg_write || (state_reg == cds_pkg::ST_WR_I && last_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (rebuild)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_rank_reg    <= 4'd1;
            shuffle_length_reg <= 6'd52;
            step_reg           <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == cds_pkg::ST_WR_I);
            if (cfg_valid && cfg_ready && cfg_index == cds_pkg::CFG_LOWEST_RANK)
                lowest_rank_reg <= cfg_data[cds_pkg::RANK_W-1:0];
            if (cfg_valid && cfg_ready && cfg_index == cds_pkg::CFG_SHUFFLE_LENGTH)
                shuffle_length_reg <= cfg_data;
            if (cfg_write)
                step_reg <= '0;
            else if (state_reg == cds_pkg::ST_WR_I)
                step_reg <= last_reg ? '0 : i_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            i_reg    <= i_start;
            rem_reg  <= len - i_start;
            last_reg <= (i_start + 6'd1 == len);
        end
        if (state_reg == cds_pkg::ST_DIV && div_done)
            j_reg <= j_calc;
        if (state_reg == cds_pkg::ST_RD_J)
            card_i_reg <= rd_card;
        if (state_reg == cds_pkg::ST_WR_J)
            card_j_reg <= rd_card;
        if (state_reg == cds_pkg::ST_WR_I)
        begin
            position_reg  <= i_reg;
            card_rank_reg <= card_j_reg[cds_pkg::RANK_W-1:0];
            card_suit_reg <= card_j_reg[cds_pkg::CARD_W-1:cds_pkg::RANK_W];
            last_card_reg <= last_reg;
        end
    end

    assign done      = done_reg;
    assign position  = position_reg;
    assign card_rank = card_rank_reg;
    assign card_suit = card_suit_reg;
    assign last_card = last_card_reg;

    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == cds_pkg::ST_WR_I))
        else $error("result strobe without a completed swap");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cds_pkg::ST_DIV && div_done) |-> (div_rem < rem_reg))
        else $error("remainder not below remaining count");

    a_rebuild_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && last_card_reg) |-> (step_reg == '0 && valid_reg == '0))
        else $error("deck not rebuilt after last card");

endmodule

@@ design/cds_divider.sv @@
// Bit-serial restoring remainder unit: random word modulo a small count.
module cds_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cds_pkg::WORD_W-1:0]  dividend,
    input  logic [cds_pkg::POS_W-1:0]   divisor,
    output logic                        done,
    output logic [cds_pkg::POS_W-1:0]   remainder
);

    logic [cds_pkg::WORD_W-1:0]    word_reg;
    logic [cds_pkg::POS_W-1:0]     div_reg;
    logic [cds_pkg::POS_W-1:0]     rem_reg;
    logic [cds_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          run_reg;
    logic                          done_reg;
    logic [cds_pkg::POS_W:0]       trial;
    logic [cds_pkg::POS_W-1:0]     rem_next;

    always_comb
    begin
        trial = {rem_reg, word_reg[cds_pkg::WORD_W-1]};
        if (trial >= {1'b0, div_reg})
            rem_next = cds_pkg::POS_W'(trial - {1'b0, div_reg});
        else
            rem_next = trial[cds_pkg::POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == cds_pkg::DIV_CNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= cds_pkg::DIV_CNT_W'(cds_pkg::WORD_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - cds_pkg::DIV_CNT_W'(1);
                if (cnt_reg == cds_pkg::DIV_CNT_W'(1))
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            word_reg <= dividend;
            div_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            word_reg <= word_reg << 1;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
